>>> design/tlrl_pkg.sv
// Package for the three-level route lookup: table geometry, controller state,
// command and status structs, and the address helper functions.
// No dependencies; used by every module of the block.
`default_nettype none

package tlrl_pkg;

    localparam int LEVEL1_BITS     = 16;
    localparam int LEVEL2_BITS     = 8;
    localparam int LEVEL3_BITS     = 8;
    localparam int TABLE_ADDR_BITS = 16;
    localparam int ENTRY_BITS      = 16;

    localparam int KEY_W       = 32;
    localparam int HOP_W       = 8;
    localparam int BASE_W      = 16;
    localparam int CFG_INDEX_W = 8;

    localparam logic [15:0] UPDATE_CODE = 16'd1000;
    localparam logic [15:0] L2_WR_MASK  = 16'hfffe;
    localparam logic [15:0] L3_WR_MASK  = 16'hfffd;

    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL2_BASE = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_LEVEL3_BASE = CFG_INDEX_W'(1);

    typedef logic [TABLE_ADDR_BITS-1:0] addr_t;
    typedef logic [ENTRY_BITS-1:0]      entry_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic clear;
        logic load_key;
        logic acc1;
        logic acc2;
        logic acc3;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
    } status_t;

    // Key bits starting 'used' bits below the top, zero filled past the end,
    // reduced to a table address.
    function automatic addr_t key_slice(input logic [KEY_W-1:0] k,
                                        input int used, input int width);
        logic [63:0] w;
        logic [63:0] m;
        w = {k, 32'd0} >> (64 - used - width);
        m = (64'd1 << width) - 64'd1;
        w = w & m;
        return w[TABLE_ADDR_BITS-1:0];
    endfunction

    // Entry shifted to the start of its chunk, reduced to a table address.
    function automatic addr_t entry_shift(input entry_t e, input int sh);
        logic [63:0] w;
        w = 64'(e) << sh;
        return w[TABLE_ADDR_BITS-1:0];
    endfunction

endpackage

`default_nettype wire

>>> design/tlrl_ctrl.sv
// Controller for the route lookup: clearing pass after reset, then one
// table level per state. Depends on tlrl_pkg.
`default_nettype none

module tlrl_ctrl
    import tlrl_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire status_t status,
    output cmd_t         cmd,
    output logic         busy,
    output logic         done
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: if (status.clear_last) state_next = ST_IDLE;
            ST_IDLE:  if (start) state_next = ST_RD1;
            ST_RD1:   state_next = ST_RD2;
            ST_RD2:   state_next = ST_RD3;
            ST_RD3:   state_next = ST_DONE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_CLEAR;
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        done = 1'b0;
        unique case (state_reg)
            ST_CLEAR: cmd.clear = 1'b1;
            ST_IDLE:
            begin
                busy         = 1'b0;
                cmd.load_key = start;
            end
            ST_RD1:   cmd.acc1 = 1'b1;
            ST_RD2:   cmd.acc2 = 1'b1;
            ST_RD3:   cmd.acc3 = 1'b1;
            ST_DONE:  done = 1'b1;
            default:  busy = 1'b1;
        endcase
    end

endmodule

`default_nettype wire

>>> design/tlrl_datapath.sv
// Datapath for the route lookup: key and base registers, the three table
// memories with registered read data, and the clearing counter.
// Depends on tlrl_pkg.
`default_nettype none

module tlrl_datapath
    import tlrl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire cmd_t                   cmd,
    output status_t                     status,
    input  wire logic [KEY_W-1:0]       key,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [BASE_W-1:0]      cfg_data,
    output logic [HOP_W-1:0]            next_hop
);

    localparam int DEPTH = 1 << TABLE_ADDR_BITS;

    entry_t first_table  [DEPTH];
    entry_t second_table [DEPTH];
    entry_t third_table  [DEPTH];

    logic [KEY_W-1:0]  key_reg;
    logic [BASE_W-1:0] level2_base_reg;
    logic [BASE_W-1:0] level3_base_reg;
    addr_t             clr_cnt_reg;
    entry_t            rdata1_reg;
    entry_t            rdata2_reg;
    entry_t            rdata3_reg;

    logic [15:0] low_key;
    entry_t      wdata;
    addr_t       acc_addr1;
    addr_t       acc_addr2;
    addr_t       acc_addr3;
    addr_t       addr1;
    addr_t       addr2;
    addr_t       addr3;
    logic        we1;
    logic        we2;
    logic        we3;
    entry_t      wd;

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
            key_reg <= key;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level2_base_reg <= '0;
            level3_base_reg <= '0;
            clr_cnt_reg     <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_LEVEL2_BASE: level2_base_reg <= cfg_data;
                    REG_LEVEL3_BASE: level3_base_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.clear)
                clr_cnt_reg <= clr_cnt_reg + addr_t'(1);
        end
    end

    assign status.clear_last = &clr_cnt_reg;

    assign low_key = key_reg[15:0];
    assign wdata   = ENTRY_BITS'({16'd0, key_reg[KEY_W-1:16]});

    // Each level's address wraps at the table size.
    assign acc_addr1 = key_slice(key_reg, 0, LEVEL1_BITS);
    assign acc_addr2 = addr_t'(level2_base_reg) + entry_shift(rdata1_reg, LEVEL2_BITS)
                     + key_slice(key_reg, LEVEL1_BITS, LEVEL2_BITS);
    assign acc_addr3 = addr_t'(level3_base_reg) + entry_shift(rdata2_reg, LEVEL3_BITS)
                     + key_slice(key_reg, LEVEL1_BITS + LEVEL2_BITS, LEVEL3_BITS);

    assign addr1 = cmd.clear ? clr_cnt_reg : acc_addr1;
    assign addr2 = cmd.clear ? clr_cnt_reg : acc_addr2;
    assign addr3 = cmd.clear ? clr_cnt_reg : acc_addr3;

    assign we1 = cmd.clear | (cmd.acc1 & (low_key == UPDATE_CODE));
    assign we2 = cmd.clear | (cmd.acc2 & ((low_key & L2_WR_MASK) == UPDATE_CODE));
    assign we3 = cmd.clear | (cmd.acc3 & ((low_key & L3_WR_MASK) == UPDATE_CODE));
    assign wd  = cmd.clear ? '0 : wdata;

    // Read takes the old entry even when the same address is written.
    always_ff @(posedge clk)
    begin
        if (we1)
            first_table[addr1] <= wd;
        rdata1_reg <= first_table[addr1];
    end

    always_ff @(posedge clk)
    begin
        if (we2)
            second_table[addr2] <= wd;
        rdata2_reg <= second_table[addr2];
    end

    always_ff @(posedge clk)
    begin
        if (we3)
            third_table[addr3] <= wd;
        rdata3_reg <= third_table[addr3];
    end

    assign next_hop = rdata3_reg[HOP_W-1:0];

endmodule

`default_nettype wire

>>> design/three_level_ip_route_lookup_core.sv
// Top level of the three-level route lookup: controller plus datapath.
// Depends on tlrl_pkg, tlrl_ctrl and tlrl_datapath.
//
// Use:
//   Present a key with start high; it is taken at an edge where busy is low.
//   The item walks the first, second and third table, one table read per
//   cycle, each table having a single port with registered read data.
//   done is high for one cycle, once the third table read is registered,
//   with next_hop valid in that cycle; busy falls in the cycle after done.
//   An item holds the block until busy falls, set by the chain of
//   dependent table reads. Update keys write their level in the same cycle
//   as its read, and the old entry travels on.
//   Results cannot be held off: the receiver must take done when it comes.
//   Configuration writes on cfg_valid/cfg_data/cfg_index are always ready;
//   the user must make them only while the block is idle; the block does not enforce this.
//   After reset a clearing pass zeroes all 2^TABLE_ADDR_BITS = 65536 entries
//   of each of the three tables, one entry of each per cycle; busy is high meanwhile.
`default_nettype none

module three_level_ip_route_lookup_core
    import tlrl_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [KEY_W-1:0]       key,
    output logic                        done,
    output logic [HOP_W-1:0]            next_hop,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [BASE_W-1:0]      cfg_data
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    tlrl_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done)
    );

    tlrl_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .key       (key),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .next_hop  (next_hop)
    );

`ifndef NO_ASSERTIONS
    a_done_follows_lookup: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(cmd.acc3))
        else $error("done without a third-level access");

    a_accept_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && cmd.acc1))
        else $error("accepted item did not start the first level");

    a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear |-> (!done && busy))
        else $error("result or idle during clearing pass");
`endif

endmodule

`default_nettype wire
